[hw/rtl/kcl_pkg.sv]
package kcl_pkg;

  localparam int unsigned NumRegs   = 6;
  localparam int unsigned KeyW      = 5;
  localparam int unsigned CodeW     = 4;
  localparam int unsigned GrpW      = 3;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned DataW     = 32;
  localparam int unsigned RegIdxW   = 3;

  typedef logic [KeyW-1:0]  key_t;
  typedef logic [CodeW-1:0] code_t;
  typedef logic [GrpW-1:0]  grp_t;

  // One key code per digit group: start key first, then the five digits.
  typedef code_t [NumRegs-1:0] code_regs_t;

  typedef enum logic [RegIdxW-1:0] {
    REG_START_KEY    = 3'd0,
    REG_DIGIT_ONE    = 3'd1,
    REG_DIGIT_TWO    = 3'd2,
    REG_DIGIT_THREE  = 3'd3,
    REG_DIGIT_FOUR   = 3'd4,
    REG_DIGIT_FIVE   = 3'd5
  } reg_idx_t;

  localparam key_t  KeyIdle   = 5'd31;
  localparam grp_t  LastGroup = 3'd5;
  localparam grp_t  FirstGroup = 3'd0;

  localparam code_t StartKeyReset = 4'd15;
  localparam code_t DigitOneReset = 4'd1;
  localparam code_t DigitTwoReset = 4'd2;
  localparam code_t DigitThreeReset = 4'd3;
  localparam code_t DigitFourReset = 4'd4;
  localparam code_t DigitFiveReset = 4'd5;

  // Key code that the given group waits for.
  function automatic code_t group_target(code_regs_t codes, grp_t grp);
    code_t res;
    case (grp)
      3'd0: res = codes[REG_START_KEY];
      3'd1: res = codes[REG_DIGIT_ONE];
      3'd2: res = codes[REG_DIGIT_TWO];
      3'd3: res = codes[REG_DIGIT_THREE];
      3'd4: res = codes[REG_DIGIT_FOUR];
      3'd5: res = codes[REG_DIGIT_FIVE];
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

[hw/rtl/kcl_in_if.sv]
interface kcl_in_if;
  logic              valid;
  logic              ready;
  kcl_pkg::key_t     key_code;
  logic              lock_button;

  modport source (output valid, output key_code, output lock_button, input ready);
  modport sink   (input valid, input key_code, input lock_button, output ready);
endinterface

[hw/rtl/kcl_out_if.sv]
interface kcl_out_if;
  logic valid;
  logic ready;
  logic indicator;
  logic door_open;

  modport source (output valid, output indicator, output door_open, input ready);
  modport sink   (input valid, input indicator, input door_open, output ready);
endinterface

[hw/rtl/kcl_cfg_regs.sv]
module kcl_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kcl_pkg::AddrW-1:0]    paddr,
  input  logic [kcl_pkg::DataW-1:0]    pwdata,
  output logic [kcl_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  output kcl_pkg::code_regs_t          codes
);

  kcl_pkg::code_regs_t codes_r;
  logic [kcl_pkg::RegIdxW-1:0] reg_idx;
  logic wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[kcl_pkg::AddrW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign codes   = codes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r[kcl_pkg::REG_START_KEY]   <= kcl_pkg::StartKeyReset;
      codes_r[kcl_pkg::REG_DIGIT_ONE]   <= kcl_pkg::DigitOneReset;
      codes_r[kcl_pkg::REG_DIGIT_TWO]   <= kcl_pkg::DigitTwoReset;
      codes_r[kcl_pkg::REG_DIGIT_THREE] <= kcl_pkg::DigitThreeReset;
      codes_r[kcl_pkg::REG_DIGIT_FOUR]  <= kcl_pkg::DigitFourReset;
      codes_r[kcl_pkg::REG_DIGIT_FIVE]  <= kcl_pkg::DigitFiveReset;
    end else if (wr_en) begin
      case (reg_idx)
        kcl_pkg::REG_START_KEY:   codes_r[kcl_pkg::REG_START_KEY]   <= pwdata[kcl_pkg::CodeW-1:0];
        kcl_pkg::REG_DIGIT_ONE:   codes_r[kcl_pkg::REG_DIGIT_ONE]   <= pwdata[kcl_pkg::CodeW-1:0];
        kcl_pkg::REG_DIGIT_TWO:   codes_r[kcl_pkg::REG_DIGIT_TWO]   <= pwdata[kcl_pkg::CodeW-1:0];
        kcl_pkg::REG_DIGIT_THREE: codes_r[kcl_pkg::REG_DIGIT_THREE] <= pwdata[kcl_pkg::CodeW-1:0];
        kcl_pkg::REG_DIGIT_FOUR:  codes_r[kcl_pkg::REG_DIGIT_FOUR]  <= pwdata[kcl_pkg::CodeW-1:0];
        kcl_pkg::REG_DIGIT_FIVE:  codes_r[kcl_pkg::REG_DIGIT_FIVE]  <= pwdata[kcl_pkg::CodeW-1:0];
        default: ;
      endcase
    end
  end

  // Addresses past the last register read as zero.
  always_comb begin
    prdata = '0;
    case (reg_idx)
      kcl_pkg::REG_START_KEY:   prdata[kcl_pkg::CodeW-1:0] = codes_r[kcl_pkg::REG_START_KEY];
      kcl_pkg::REG_DIGIT_ONE:   prdata[kcl_pkg::CodeW-1:0] = codes_r[kcl_pkg::REG_DIGIT_ONE];
      kcl_pkg::REG_DIGIT_TWO:   prdata[kcl_pkg::CodeW-1:0] = codes_r[kcl_pkg::REG_DIGIT_TWO];
      kcl_pkg::REG_DIGIT_THREE: prdata[kcl_pkg::CodeW-1:0] = codes_r[kcl_pkg::REG_DIGIT_THREE];
      kcl_pkg::REG_DIGIT_FOUR:  prdata[kcl_pkg::CodeW-1:0] = codes_r[kcl_pkg::REG_DIGIT_FOUR];
      kcl_pkg::REG_DIGIT_FIVE:  prdata[kcl_pkg::CodeW-1:0] = codes_r[kcl_pkg::REG_DIGIT_FIVE];
      default: prdata = '0;
    endcase
  end

endmodule

[hw/rtl/kcl_step.sv]
module kcl_step (
  input  logic                clk,
  input  logic                rst_n,
  kcl_in_if.sink              in_bus,
  kcl_out_if.source           out_bus,
  input  kcl_pkg::code_regs_t codes
);

  typedef enum logic [4:0] {
    SUB_WAIT   = 5'b00001,
    SUB_PRESS  = 5'b00010,
    SUB_REL    = 5'b00100,
    SUB_LOCK   = 5'b01000,
    SUB_RELOCK = 5'b10000
  } sub_t;

  // Input stage.
  logic          in_vld_r;
  kcl_pkg::key_t key_r;
  logic          btn_r;

  // Sequence state; the levels double as the result register.
  sub_t          sub_r, sub_nxt;
  kcl_pkg::grp_t grp_r, grp_nxt;
  logic          ind_r, ind_nxt;
  logic          door_r, door_nxt;
  logic          out_vld_r;

  logic          fire;
  logic          in_take;
  logic          key_hit;
  kcl_pkg::code_t target;

  assign fire         = in_vld_r && (!out_vld_r || out_bus.ready);
  assign in_bus.ready = !in_vld_r || fire;
  assign in_take      = in_bus.valid && in_bus.ready;

  assign target  = kcl_pkg::group_target(codes, grp_r);
  assign key_hit = key_r == {1'b0, target};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_take || (in_vld_r && !fire);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      key_r <= in_bus.key_code;
      btn_r <= in_bus.lock_button;
    end
  end

  always_comb begin
    sub_nxt  = sub_r;
    grp_nxt  = grp_r;
    ind_nxt  = ind_r;
    door_nxt = door_r;
    case (sub_r)
      SUB_WAIT: begin
        if (key_hit) begin
          sub_nxt = SUB_PRESS;
          ind_nxt = 1'b1;
        end else if (key_r != kcl_pkg::KeyIdle) begin
          grp_nxt = kcl_pkg::FirstGroup;
        end
      end
      SUB_PRESS: begin
        sub_nxt = SUB_REL;
        ind_nxt = 1'b0;
        if (grp_r == kcl_pkg::LastGroup) begin
          door_nxt = 1'b1;
        end
      end
      SUB_REL: begin
        if (key_hit) begin
          sub_nxt = SUB_PRESS;
          ind_nxt = 1'b1;
        end else if (grp_r == kcl_pkg::LastGroup) begin
          sub_nxt = SUB_LOCK;
        end else begin
          sub_nxt = SUB_WAIT;
          grp_nxt = grp_r + 1'b1;
        end
      end
      SUB_LOCK: begin
        if (btn_r) begin
          sub_nxt  = SUB_RELOCK;
          door_nxt = 1'b0;
        end
      end
      SUB_RELOCK: begin
        sub_nxt = SUB_WAIT;
        grp_nxt = kcl_pkg::FirstGroup;
      end
      default: begin
        sub_nxt = SUB_WAIT;
        grp_nxt = kcl_pkg::FirstGroup;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r     <= SUB_WAIT;
      grp_r     <= kcl_pkg::FirstGroup;
      ind_r     <= 1'b0;
      door_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (fire) begin
        sub_r  <= sub_nxt;
        grp_r  <= grp_nxt;
        ind_r  <= ind_nxt;
        door_r <= door_nxt;
      end
      out_vld_r <= fire || (out_vld_r && !out_bus.ready);
    end
  end

  assign out_bus.valid     = out_vld_r;
  assign out_bus.indicator = ind_r;
  assign out_bus.door_open = door_r;

`ifndef NO_ASSERTIONS
  a_fire_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("processed item produced no result beat");

  a_ind_only_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    ind_r == (sub_r == SUB_PRESS))
    else $error("indicator level disagrees with pressed state");

  a_door_state: assert property (@(posedge clk) disable iff (!rst_n)
    door_r |-> (sub_r == SUB_LOCK) ||
               ((grp_r == kcl_pkg::LastGroup) && ((sub_r == SUB_PRESS) || (sub_r == SUB_REL))))
    else $error("door open outside the final digit or lock wait");

  a_door_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(door_r) |-> (sub_r == SUB_REL) && (grp_r == kcl_pkg::LastGroup))
    else $error("door opened without release of the last digit");
`endif

endmodule

[hw/rtl/keypad_combination_lock.sv]
// Keypad combination lock. Each input beat carries one decoded keypad sample
// (key_code: 0-15 a key, 31 no key, anything else invalid) and the lock button,
// and yields exactly one result beat with the indicator and door levels after
// that sample. The unlock sequence is the start key followed by five code
// digits, each a press and a release; a repeated press of the same key is
// allowed, the idle code keeps the lock waiting, and any other wrong key
// returns it to the start. The door stays open until the lock button is seen.
// The start key and the five digits are registers 0 to 5 on the APB port at
// byte addresses 0x00 to 0x14 (reset 15, 1, 2, 3, 4, 5); only the low four
// bits of a write are kept. Write them only while no beat is in flight.
// Throughput is one beat per clock while the result side is ready: a sample
// is captured in an input register, and the sequence step is a single level
// of compare-and-select logic between that register and the state/result
// register, which offers the result once it is loaded.
// Back-pressure on the result side stalls the step, and the input register then
// holds one more beat.

module keypad_combination_lock (
  input  logic                         clk,
  input  logic                         rst_n,
  kcl_in_if.sink                       in_bus,
  kcl_out_if.source                    out_bus,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kcl_pkg::AddrW-1:0]    paddr,
  input  logic [kcl_pkg::DataW-1:0]    pwdata,
  output logic [kcl_pkg::DataW-1:0]    prdata,
  output logic                         pready
);

  // Current combination, one four-bit key code per group.
  kcl_pkg::code_regs_t codes;

  kcl_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .codes   (codes)
  );

  // Sequence engine: input register, step logic and result register.
  kcl_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .codes   (codes)
  );

endmodule

[dv/keypad_combination_lock_test.sv]
`timescale 1ns / 100ps

// Stimulus is a mix of scripted walk-throughs, well-formed unlock attempts with
// random content, broken attempts and plain keypad noise. Every accepted input
// beat is run through a local model of the lock sequence. The model's levels
// are queued, and the checker pops them in order as result beats arrive.
module keypad_combination_lock_test;

  // Phase numbering: three phases per digit group (wait, pressed, released),
  // then the two phases that follow the final release.
  localparam int SubWait       = 0;
  localparam int SubPressed    = 1;
  localparam int SubReleased   = 2;
  localparam int GroupSpan     = 3;
  localparam int PhaseStart    = 0;
  localparam int PhaseWaitLock = GroupSpan * kcl_pkg::NumRegs;
  localparam int PhaseRelock   = PhaseWaitLock + 1;
  localparam int LastRelease   = PhaseWaitLock - 1;

  // Register indexes past the last code register. Writes there must be dropped.
  localparam int UnusedIdxLow  = kcl_pkg::NumRegs;
  localparam int UnusedIdxHigh = kcl_pkg::NumRegs + 1;

  // The result is offered after the input and the state/result registers. Allow a margin.
  localparam int SettleCycles  = 8;
  localparam int LongStall     = 300;

  typedef struct packed {
    logic indicator;
    logic door_open;
  } lock_levels_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [kcl_pkg::AddrW-1:0] paddr;
  logic [kcl_pkg::DataW-1:0] pwdata;
  logic [kcl_pkg::DataW-1:0] prdata;
  logic pready;

  kcl_in_if  in_bus ();
  kcl_out_if out_bus ();

  keypad_combination_lock dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk = ~clk;

  // Local copy of the lock: code registers, sequence phase and output levels.
  kcl_pkg::code_t key_codes [kcl_pkg::NumRegs];
  logic [4:0]     lock_phase;
  logic           lock_ind;
  logic           lock_door;
  lock_levels_t   pending_levels [$];

  int  error_count   = 0;
  int  beats_sent    = 0;
  bit  idling_on     = 1'b1;
  int  long_stall_req = 0;

  function automatic void reset_lock_model();
    key_codes[kcl_pkg::REG_START_KEY]   = kcl_pkg::StartKeyReset;
    key_codes[kcl_pkg::REG_DIGIT_ONE]   = kcl_pkg::DigitOneReset;
    key_codes[kcl_pkg::REG_DIGIT_TWO]   = kcl_pkg::DigitTwoReset;
    key_codes[kcl_pkg::REG_DIGIT_THREE] = kcl_pkg::DigitThreeReset;
    key_codes[kcl_pkg::REG_DIGIT_FOUR]  = kcl_pkg::DigitFourReset;
    key_codes[kcl_pkg::REG_DIGIT_FIVE]  = kcl_pkg::DigitFiveReset;
    lock_phase = 5'(PhaseStart);
    lock_ind   = 1'b0;
    lock_door  = 1'b0;
  endfunction

  // Where the sequence goes on one keypad sample. A wait phase advances only on
  // its own key and holds on the idle code. A pressed phase always falls to
  // released. A released phase re-presses on the same key and otherwise moves to
  // the next group.
  function automatic logic [4:0] next_lock_phase(logic [4:0] ph, kcl_pkg::key_t key,
                                                 logic button);
    int   grp;
    int   sub;
    int   base;
    logic hit;
    if (ph < PhaseWaitLock) begin
      grp  = int'(ph) / GroupSpan;
      sub  = int'(ph) % GroupSpan;
      base = grp * GroupSpan;
      hit  = (key == kcl_pkg::key_t'(key_codes[grp]));
      case (sub)
        SubWait: begin
          if (hit) return 5'(base + SubPressed);
          if (key == kcl_pkg::KeyIdle) return ph;
          return 5'(PhaseStart);
        end
        SubPressed: return 5'(base + SubReleased);
        default: return hit ? 5'(base + SubPressed) : 5'(base + GroupSpan);
      endcase
    end
    if (ph == PhaseWaitLock) return button ? 5'(PhaseRelock) : ph;
    return 5'(PhaseStart);
  endfunction

  // Step the model for one accepted beat and queue the levels it must produce.
  function automatic void advance_lock(kcl_pkg::key_t key, logic button);
    lock_phase = next_lock_phase(lock_phase, key, button);
    if (lock_phase < PhaseWaitLock) begin
      case (int'(lock_phase) % GroupSpan)
        SubPressed: lock_ind = 1'b1;
        SubReleased: begin
          lock_ind = 1'b0;
          if (lock_phase == LastRelease) lock_door = 1'b1;
        end
        default: ;
      endcase
    end else if (lock_phase == PhaseRelock) begin
      lock_door = 1'b0;
    end
    pending_levels.push_back('{indicator: lock_ind, door_open: lock_door});
  endfunction

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (!idling_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one keypad sample and hold it until the block takes it. Valid stays
  // high when the next beat follows without a gap.
  task automatic send_sample(kcl_pkg::key_t key, logic button);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.key_code    <= key;
    in_bus.lock_button <= button;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    advance_lock(key, button);
    beats_sent++;
  endtask

  // Stop offering beats and wait until every queued result has come back.
  task automatic wait_all_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_levels.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // An APB transfer: setup, then access. The transfer completes on the
  // edge where the access cycle meets pready.
  task automatic apb_transfer(input logic [kcl_pkg::AddrW-1:0] addr, input logic wr,
                              input logic [kcl_pkg::DataW-1:0] wdata,
                              output logic [kcl_pkg::DataW-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Junk goes in the upper bits, since only the low nibble may be kept.
  task automatic write_code(int idx, kcl_pkg::code_t value);
    logic [kcl_pkg::DataW-1:0] data;
    logic [kcl_pkg::DataW-1:0] unused_rd;
    data = $urandom();
    data[kcl_pkg::CodeW-1:0] = value;
    apb_transfer(kcl_pkg::AddrW'(idx * 4), 1'b1, data, unused_rd);
    if (idx < kcl_pkg::NumRegs) key_codes[idx] = value;
  endtask

  task automatic read_back_codes();
    logic [kcl_pkg::DataW-1:0] rd;
    for (int i = 0; i < kcl_pkg::NumRegs; i++) begin
      apb_transfer(kcl_pkg::AddrW'(i * 4), 1'b0, '0, rd);
      if (rd !== kcl_pkg::DataW'(key_codes[i])) begin
        $error("code register %0d: expected %0h, got %0h", i, key_codes[i], rd);
        error_count++;
      end
    end
  endtask

  // Any value that is not the given key. Half the time the idle code, otherwise random.
  function automatic kcl_pkg::key_t other_key(kcl_pkg::code_t target);
    kcl_pkg::key_t k;
    if ($urandom_range(0, 1) == 0) return kcl_pkg::KeyIdle;
    do k = kcl_pkg::key_t'($urandom_range(0, 31)); while (k == kcl_pkg::key_t'(target));
    return k;
  endfunction

  // One pass at the combination with random content. The attempt idles in wait
  // phases, holds keys over several ticks, and releases with random codes. Now
  // and then it strikes a wrong key and breaks off. A complete attempt also
  // relocks the door and takes the tick that returns the lock to the start.
  task automatic run_unlock_attempt();
    kcl_pkg::code_t target;
    kcl_pkg::key_t  wrong;
    int             presses;
    for (int g = 0; g < kcl_pkg::NumRegs; g++) begin
      target = key_codes[g];
      repeat ($urandom_range(0, 2)) send_sample(kcl_pkg::KeyIdle, 1'($urandom()));
      if ($urandom_range(0, 99) < 5) begin
        do wrong = kcl_pkg::key_t'($urandom_range(0, 30));
        while (wrong == kcl_pkg::key_t'(target));
        send_sample(wrong, 1'($urandom()));
        return;
      end
      presses = $urandom_range(1, 4);
      repeat (presses) send_sample(kcl_pkg::key_t'(target), 1'($urandom()));
      // After an odd count the key is still down, and any sample releases it.
      if (presses % 2 == 1) begin
        send_sample(kcl_pkg::key_t'($urandom_range(0, 31)), 1'($urandom()));
      end
      send_sample(other_key(target), 1'($urandom()));
    end
    // The door is open. The lock button is the only input that matters here.
    repeat ($urandom_range(0, 3)) send_sample(kcl_pkg::key_t'($urandom_range(0, 31)), 1'b0);
    send_sample(kcl_pkg::key_t'($urandom_range(0, 31)), 1'b1);
    send_sample(kcl_pkg::key_t'($urandom_range(0, 31)), 1'($urandom()));
  endtask

  // A scripted pass with the reset codes. It covers a held start key, the
  // invalid code, out-of-range codes as release values, the idle code in the wait,
  // pressed, released and relock phases, and the wait for the lock button.
  task automatic test_directed_walkthrough();
    send_sample(5'd27, 1'b1);   // invalid code at the start stays at the start
    send_sample(kcl_pkg::KeyIdle, 1'b1); // idle, button ignored
    send_sample(5'd15, 1'b0);   // start key pressed
    send_sample(5'd15, 1'b0);   // held: drops to released
    send_sample(5'd15, 1'b0);   // held: pressed again
    send_sample(kcl_pkg::KeyIdle, 1'b0); // released
    send_sample(kcl_pkg::KeyIdle, 1'b0); // on to the first digit
    send_sample(5'd1, 1'b0);
    send_sample(5'd1, 1'b1);
    send_sample(5'd2, 1'b0);    // a different key moves on without a press
    send_sample(5'd2, 1'b0);
    send_sample(5'd0, 1'b0);    // key zero releases
    send_sample(5'd16, 1'b0);   // lowest out-of-range code moves on
    send_sample(5'd3, 1'b0);
    send_sample(5'd30, 1'b0);
    send_sample(kcl_pkg::KeyIdle, 1'b0);
    send_sample(5'd4, 1'b0);
    send_sample(kcl_pkg::KeyIdle, 1'b0);
    send_sample(kcl_pkg::KeyIdle, 1'b0);
    send_sample(5'd5, 1'b0);
    send_sample(kcl_pkg::KeyIdle, 1'b0); // fifth digit released: door opens
    send_sample(kcl_pkg::KeyIdle, 1'b0); // waiting for the lock button
    send_sample(5'd9, 1'b0);
    send_sample(5'd7, 1'b1);    // lock button: door closes
    send_sample(kcl_pkg::KeyIdle, 1'b0); // back to the start
  endtask

  // Writes to every code register with junk upper bits, plus writes past the
  // last register that must be ignored, then one read back of every code register.
  task automatic test_register_access();
    write_code(kcl_pkg::REG_START_KEY, 4'hF);
    write_code(kcl_pkg::REG_DIGIT_ONE, 4'h0);
    write_code(kcl_pkg::REG_DIGIT_TWO, 4'hA);
    write_code(kcl_pkg::REG_DIGIT_THREE, 4'h5);
    write_code(kcl_pkg::REG_DIGIT_FOUR, 4'hF);
    write_code(kcl_pkg::REG_DIGIT_FIVE, 4'h0);
    write_code(UnusedIdxLow, 4'h7);
    write_code(UnusedIdxHigh, 4'h9);
    read_back_codes();
  endtask

  // Several combinations, the extremes among them, each exercised by a few
  // hundred beats of attempts mixed with noise.
  task automatic test_code_settings();
    kcl_pkg::code_t value;
    kcl_pkg::code_t shared;
    int             first;
    for (int s = 0; s < 5; s++) begin
      wait_all_results();
      shared = kcl_pkg::code_t'($urandom());
      for (int i = 0; i < kcl_pkg::NumRegs; i++) begin
        case (s)
          0: value = '0;
          1: value = '1;
          2: value = (i == kcl_pkg::REG_START_KEY) ? kcl_pkg::code_t'(0)
                                                   : kcl_pkg::code_t'(15);
          3: value = kcl_pkg::code_t'($urandom());
          default: value = shared;  // every digit equal to the start key
        endcase
        write_code(i, value);
      end
      read_back_codes();
      // One setting runs with no idling at all on either side.
      idling_on = (s != 1);
      first = beats_sent;
      while (beats_sent - first < 330) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 6))
            send_sample(kcl_pkg::key_t'($urandom_range(0, 31)), 1'($urandom()));
        end else begin
          run_unlock_attempt();
        end
      end
      idling_on = 1'b1;
    end
  endtask

  task automatic test_keypad_noise();
    repeat (200) send_sample(kcl_pkg::key_t'($urandom_range(0, 31)), 1'($urandom()));
  endtask

  // The receiver stops for a long stretch while the sender keeps offering
  // beats, so the block fills and stalls its input. Then the sender pauses
  // until every result is home before sending more.
  task automatic test_backpressure();
    int first;
    idling_on = 1'b0;
    long_stall_req = LongStall;
    first = beats_sent;
    while (beats_sent - first < 60) run_unlock_attempt();
    wait_all_results();
    idling_on = 1'b1;
    first = beats_sent;
    while (beats_sent - first < 40) run_unlock_attempt();
  endtask

  // Result-side ready: runs of acceptance broken by random gaps. A long stall
  // request is picked up here and counted down in cycles.
  initial begin : result_receiver
    int run_left;
    int gap_left;
    run_left = 0;
    gap_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall_req > 0) begin
        gap_left = long_stall_req;
        long_stall_req = 0;
      end
      if (gap_left > 0) begin
        out_bus.ready <= 1'b0;
        gap_left--;
      end else begin
        out_bus.ready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else if (idling_on) begin
          run_left = $urandom_range(0, 24);
          gap_left = pick_gap();
        end
      end
    end
  end

  // Compare each result beat with the oldest queued expectation.
  always @(posedge clk) begin : check_results
    lock_levels_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_levels.size() == 0) begin
        $error("result beat with no expectation: indicator %0b, door_open %0b",
               out_bus.indicator, out_bus.door_open);
        error_count++;
      end else begin
        want = pending_levels.pop_front();
        if (out_bus.indicator !== want.indicator) begin
          $error("indicator: expected %0b, got %0b", want.indicator, out_bus.indicator);
          error_count++;
        end
        if (out_bus.door_open !== want.door_open) begin
          $error("door_open: expected %0b, got %0b", want.door_open, out_bus.door_open);
          error_count++;
        end
      end
    end
  end

  initial begin : main_sequence
    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.key_code    <= '0;
    in_bus.lock_button <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    reset_lock_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_walkthrough();
    wait_all_results();
    test_register_access();
    test_code_settings();
    test_keypad_noise();
    test_backpressure();
    wait_all_results();

    if (error_count == 0) begin
      $display("keypad_combination_lock_test: PASS");
    end else begin
      $display("keypad_combination_lock_test: FAIL");
    end
    $finish;
  end

  // Watchdog: reports a failure and ends the simulation if it is still running.
  initial begin : watchdog
    #8000000;
    $display("keypad_combination_lock_test: FAIL");
    $finish;
  end

endmodule
